/* hdl/rwlt_pkg.sv */
// ----------------------------------------------------------------------------
// rwlt_pkg: shared types and constants for the reader/writer lock table
// Sizes of the record table, operation and status codes, and the request
// word that walks down the cell chain.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int MAX_READERS   = 255;
  localparam int PAYLOAD_WIDTH = 64;

  localparam int KEY_W      = 32;
  localparam int PORT_PAY_W = 64;
  localparam int RC_W       = $clog2(MAX_READERS + 1);

  typedef enum logic [2:0] {
    FN_EXIT       = 3'd0,
    FN_READ_START = 3'd1,
    FN_READ_DONE  = 3'd2,
    FN_WRITE_LOCK = 3'd3,
    FN_COMMIT     = 3'd4,
    FN_UNLOCK     = 3'd5,
    FN_LOAD       = 3'd6,
    FN_INVALID    = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BUSY      = 3'd2,
    ST_PROTOCOL  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Request word handed from cell to cell.
  typedef struct packed {
    logic                     active;
    logic                     done;
    func_t                    func;
    logic [KEY_W-1:0]         key;
    logic [PAYLOAD_WIDTH-1:0] data;
    status_t                  status;
    logic [PAYLOAD_WIDTH-1:0] pout;
  } tok_t;

endpackage

/* hdl/rwlt_cell.sv */
// ----------------------------------------------------------------------------
// rwlt_cell: one record slot of the lock table
// Holds one record and serves the request word that passes through it,
// then hands the word on to the next cell.
// ----------------------------------------------------------------------------
module rwlt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rwlt_pkg::tok_t    tok_in,
  output rwlt_pkg::tok_t    tok_out,
  output logic              entry_valid
);

  logic [rwlt_pkg::KEY_W-1:0]         entry_key;
  logic [rwlt_pkg::PAYLOAD_WIDTH-1:0] entry_payload;
  logic [rwlt_pkg::RC_W-1:0]          reader_count;
  logic                               writer_held;

  logic                               entry_valid_next;
  logic [rwlt_pkg::KEY_W-1:0]         entry_key_next;
  logic [rwlt_pkg::PAYLOAD_WIDTH-1:0] entry_payload_next;
  logic [rwlt_pkg::RC_W-1:0]          reader_count_next;
  logic                               writer_held_next;
  rwlt_pkg::tok_t                     tok_next;

  logic hit;
  logic take;

  assign hit = tok_in.active && !tok_in.done && entry_valid && (entry_key == tok_in.key)
               && (tok_in.func != rwlt_pkg::FN_EXIT) && (tok_in.func != rwlt_pkg::FN_LOAD);
  assign take = tok_in.active && !tok_in.done && !entry_valid
                && (tok_in.func == rwlt_pkg::FN_LOAD);

  always_comb begin
    entry_valid_next   = entry_valid;
    entry_key_next     = entry_key;
    entry_payload_next = entry_payload;
    reader_count_next  = reader_count;
    writer_held_next   = writer_held;
    tok_next           = tok_in;
    if (take) begin
      // first free slot: append the record here
      entry_valid_next   = 1'b1;
      entry_key_next     = tok_in.key;
      entry_payload_next = tok_in.data;
      reader_count_next  = '0;
      writer_held_next   = 1'b0;
      tok_next.done      = 1'b1;
      tok_next.status    = rwlt_pkg::ST_OK;
    end else if (hit) begin
      tok_next.done   = 1'b1;
      tok_next.status = rwlt_pkg::ST_OK;
      unique case (tok_in.func)
        rwlt_pkg::FN_READ_START: begin
          if (writer_held || reader_count == rwlt_pkg::RC_W'(rwlt_pkg::MAX_READERS)) begin
            tok_next.status = rwlt_pkg::ST_BUSY;
          end else begin
            reader_count_next = reader_count + 1'b1;
            tok_next.pout     = entry_payload;
          end
        end
        rwlt_pkg::FN_READ_DONE: begin
          if (reader_count == '0) begin
            tok_next.status = rwlt_pkg::ST_PROTOCOL;
          end else begin
            reader_count_next = reader_count - 1'b1;
          end
        end
        rwlt_pkg::FN_WRITE_LOCK: begin
          if (writer_held || reader_count != '0) begin
            tok_next.status = rwlt_pkg::ST_BUSY;
          end else begin
            writer_held_next = 1'b1;
            tok_next.pout    = entry_payload;
          end
        end
        rwlt_pkg::FN_COMMIT: begin
          if (!writer_held) begin
            tok_next.status = rwlt_pkg::ST_PROTOCOL;
          end else begin
            entry_payload_next = tok_in.data;
          end
        end
        rwlt_pkg::FN_UNLOCK: begin
          if (!writer_held) begin
            tok_next.status = rwlt_pkg::ST_PROTOCOL;
          end else begin
            writer_held_next = 1'b0;
          end
        end
        default: begin
          tok_next.status = rwlt_pkg::ST_PROTOCOL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= 1'b0;
      reader_count   <= '0;
      writer_held    <= 1'b0;
      tok_out.active <= 1'b0;
    end else if (advance) begin
      entry_valid    <= entry_valid_next;
      reader_count   <= reader_count_next;
      writer_held    <= writer_held_next;
      tok_out        <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_key     <= entry_key_next;
      entry_payload <= entry_payload_next;
    end
  end

  a_excl_lock: assert property (@(posedge clk) disable iff (rst)
    !(writer_held && reader_count != '0))
    else $error("writer and readers hold the same record");

  a_free_unlocked: assert property (@(posedge clk) disable iff (rst)
    !entry_valid |-> (reader_count == '0 && !writer_held))
    else $error("free slot carries a lock");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    advance && tok_in.active && tok_in.done |=> tok_out.done)
    else $error("served request lost its result");

endmodule

/* hdl/record_reader_writer_lock_table.sv */
// ----------------------------------------------------------------------------
// record_reader_writer_lock_table: keyed record table with reader/writer locks
// Top level: entry register, chain of record cells and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the in channel (func, key, payload_in) and each one
//   gives exactly one result word on the out channel (status, payload_out).
//   A word moves when its valid is high and its stall is low.
//   Each request word enters a register and then walks down a row of
//   TABLE_DEPTH cells, one cell per cycle unless the row is stalled; each
//   cell holds one record. The first valid cell whose key matches serves
//   the word, and a load is taken by the first free cell. A word that leaves
//   the row unserved becomes not found (or table full for a load).
//   Path: a result passes the entry register, every cell of the row and
//   then the result register on its way out.
//   Throughput: one request per cycle unless stalled; requests follow
//   each other down the row in order, so a later one sees every earlier update.
//   Stall: while a result waits under stall, the whole row holds and the in
//   channel stalls too; nothing is dropped.
//   Reset: clears every record slot and all locks, and empties the row and
//   the result register. The block accepts a request right after reset.
// ----------------------------------------------------------------------------
module record_reader_writer_lock_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic signed [31:0] key,
  input  logic [63:0] payload_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] payload_out
);

  localparam int D = rwlt_pkg::TABLE_DEPTH;

  rwlt_pkg::tok_t         chain [0:D];
  rwlt_pkg::tok_t         tok_entry;
  logic [D-1:0]           valid_vec;
  logic                   advance;
  rwlt_pkg::status_t      final_status;

  // the whole row moves together unless a result waits under stall
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // build the request word; exit is marked served right here
  always_comb begin
    tok_entry.active = in_valid;
    tok_entry.func   = rwlt_pkg::func_t'(func);
    tok_entry.key    = key;
    tok_entry.data   = payload_in[rwlt_pkg::PAYLOAD_WIDTH-1:0];
    tok_entry.pout   = '0;
    tok_entry.done   = (rwlt_pkg::func_t'(func) == rwlt_pkg::FN_EXIT);
    tok_entry.status = rwlt_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].active <= 1'b0;
    end else if (advance) begin
      chain[0] <= tok_entry;
    end
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    rwlt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .tok_in      (chain[g]),
      .tok_out     (chain[g+1]),
      .entry_valid (valid_vec[g])
    );
  end

  // unserved at the end of the row: no match, or no free slot for a load
  always_comb begin
    final_status = chain[D].status;
    if (!chain[D].done) begin
      final_status = (chain[D].func == rwlt_pkg::FN_LOAD) ? rwlt_pkg::ST_FULL
                                                           : rwlt_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid   <= chain[D].active;
      status      <= final_status;
      payload_out <= chain[D].done ? rwlt_pkg::PORT_PAY_W'(chain[D].pout)
                                   : '0;
    end
  end

  a_fill_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied slots are not packed from the bottom");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    chain[D].active && !chain[D].done && chain[D].func == rwlt_pkg::FN_LOAD
      |-> (&valid_vec))
    else $error("load rejected while a slot is free");

  a_exit_served: assert property (@(posedge clk) disable iff (rst)
    chain[D].active && chain[D].func == rwlt_pkg::FN_EXIT
      |-> chain[D].done && chain[D].status == rwlt_pkg::ST_OK)
    else $error("exit request not answered ok");

endmodule

/* sim/lock_table_checker.sv */
// ----------------------------------------------------------------------------
// lock_table_checker: scoreboard for the reader/writer lock table
// Watches both channels, predicts every result word from its own copy of
// the record table and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module lock_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] key,
  input  logic [63:0] payload_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [63:0] payload_out,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rwlt_pkg::status_t                 st;
    logic [rwlt_pkg::PORT_PAY_W-1:0]   pay;
  } reply_t;

  // Shadow copy of the record table.
  logic                               rec_valid   [rwlt_pkg::TABLE_DEPTH];
  logic [rwlt_pkg::KEY_W-1:0]         rec_key     [rwlt_pkg::TABLE_DEPTH];
  logic [rwlt_pkg::PAYLOAD_WIDTH-1:0] rec_data    [rwlt_pkg::TABLE_DEPTH];
  int unsigned                        rec_readers [rwlt_pkg::TABLE_DEPTH];
  logic                               rec_writer  [rwlt_pkg::TABLE_DEPTH];
  int unsigned                        rec_fill;

  reply_t expected_replies[$];
  reply_t want;
  reply_t pred;

  function automatic int find_record(logic [rwlt_pkg::KEY_W-1:0] k);
    for (int i = 0; i < rwlt_pkg::TABLE_DEPTH; i++) begin
      if (rec_valid[i] && rec_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the reply it earns.
  function automatic reply_t serve_request(rwlt_pkg::func_t op,
                                           logic [rwlt_pkg::KEY_W-1:0] k,
                                           logic [rwlt_pkg::PORT_PAY_W-1:0] d);
    reply_t r;
    int     slot;
    r.st  = rwlt_pkg::ST_OK;
    r.pay = '0;
    if (op == rwlt_pkg::FN_EXIT) begin
      r.st = rwlt_pkg::ST_OK;
    end else if (op == rwlt_pkg::FN_LOAD) begin
      if (rec_fill >= rwlt_pkg::TABLE_DEPTH) begin
        r.st = rwlt_pkg::ST_FULL;
      end else begin
        rec_valid[rec_fill]   = 1'b1;
        rec_key[rec_fill]     = k;
        rec_data[rec_fill]    = d[rwlt_pkg::PAYLOAD_WIDTH-1:0];
        rec_readers[rec_fill] = 0;
        rec_writer[rec_fill]  = 1'b0;
        rec_fill++;
      end
    end else begin
      slot = find_record(k);
      if (slot < 0) begin
        r.st = rwlt_pkg::ST_NOT_FOUND;
      end else begin
        case (op)
          rwlt_pkg::FN_READ_START: begin
            if (rec_writer[slot] || rec_readers[slot] >= rwlt_pkg::MAX_READERS) begin
              r.st = rwlt_pkg::ST_BUSY;
            end else begin
              rec_readers[slot]++;
              r.pay = rwlt_pkg::PORT_PAY_W'(rec_data[slot]);
            end
          end
          rwlt_pkg::FN_READ_DONE: begin
            if (rec_readers[slot] == 0) r.st = rwlt_pkg::ST_PROTOCOL;
            else rec_readers[slot]--;
          end
          rwlt_pkg::FN_WRITE_LOCK: begin
            if (rec_writer[slot] || rec_readers[slot] > 0) begin
              r.st = rwlt_pkg::ST_BUSY;
            end else begin
              rec_writer[slot] = 1'b1;
              r.pay = rwlt_pkg::PORT_PAY_W'(rec_data[slot]);
            end
          end
          rwlt_pkg::FN_COMMIT: begin
            if (!rec_writer[slot]) r.st = rwlt_pkg::ST_PROTOCOL;
            else rec_data[slot] = d[rwlt_pkg::PAYLOAD_WIDTH-1:0];
          end
          rwlt_pkg::FN_UNLOCK: begin
            if (!rec_writer[slot]) r.st = rwlt_pkg::ST_PROTOCOL;
            else rec_writer[slot] = 1'b0;
          end
          default: r.st = rwlt_pkg::ST_PROTOCOL;
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rwlt_pkg::TABLE_DEPTH; i++) begin
        rec_valid[i]   = 1'b0;
        rec_key[i]     = '0;
        rec_data[i]    = '0;
        rec_readers[i] = 0;
        rec_writer[i]  = 1'b0;
      end
      rec_fill = 0;
      expected_replies.delete();
    end else begin
      // Predict first: a word leaving now always belongs to an older request.
      if (in_valid && !in_stall) begin
        pred = serve_request(rwlt_pkg::func_t'(func), key, payload_in);
        expected_replies.insert(expected_replies.size(), pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("result word with nothing expected: status %0d, payload_out %h",
                 status, payload_out);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fail_count++;
          end
          if (payload_out !== want.pay) begin
            $error("payload_out: expected %h, actual %h", want.pay, payload_out);
            fail_count++;
          end
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

/* sim/record_reader_writer_lock_table_tb.sv */
// ----------------------------------------------------------------------------
// record_reader_writer_lock_table_tb: stimulus and verdict for the lock table
// Drives directed and random request words under several idle patterns,
// including a long receiver hold-off; a checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module record_reader_writer_lock_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} idle_phase_t;

  localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] KEY_ZERO = 32'h0000_0000;
  localparam logic [31:0] KEY_NEG1 = 32'hffff_ffff;
  localparam int RANDOM_WORDS = 160;
  localparam int HOLD_CYCLES  = 300;

  logic            clk        = 1'b0;
  logic            rst        = 1'b1;
  logic            in_valid   = 1'b0;
  logic            in_stall;
  rwlt_pkg::func_t func       = rwlt_pkg::FN_EXIT;
  logic [31:0]     key        = '0;
  logic [63:0]     payload_in = '0;
  logic            out_valid;
  logic            out_stall  = 1'b0;
  logic [2:0]      status;
  logic [63:0]     payload_out;

  idle_phase_t idle_phase = PH_STEADY;
  bit          hold_go    = 1'b0;
  bit          hold_on    = 1'b0;
  int          mismatches;
  int          pending;
  int          words_sent = 0;
  logic [31:0] key_pool[$];

  always #4 clk = ~clk;

  record_reader_writer_lock_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .payload_in  (payload_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .payload_out (payload_out)
  );

  lock_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .payload_in  (payload_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .payload_out (payload_out),
    .fail_count  (mismatches),
    .pending     (pending)
  );

  function automatic bit sender_idles();
    case (idle_phase)
      PH_SEND_GAPS: return $urandom_range(99) < 46;
      PH_BOTH:      return $urandom_range(99) < 33;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_phase)
      PH_RECV_STALLS: return $urandom_range(99) < 46;
      PH_BOTH:        return $urandom_range(99) < 33;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly keys the table knows, sometimes a stranger.
  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(99) < 80)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom;
  endfunction

  // Receiver: stall at random, and hold stall high through the long hold-off.
  always @(negedge clk) begin
    out_stall <= hold_on || (!rst && receiver_stalls());
  end

  // Long hold-off, counted here on the rising edge so the receiver sees it
  // cleanly at the next falling edge.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Offer one word, called at a falling edge; return at the falling edge after
  // it is accepted with valid still high, so back-to-back words never dip.
  task automatic send_word(rwlt_pkg::func_t f, logic [31:0] k, logic [63:0] d);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    key        <= k;
    payload_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (f == rwlt_pkg::FN_LOAD && key_pool.size() < 24)
      key_pool.insert(key_pool.size(), k);
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int          base;
    int          pick;
    logic [31:0] k;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extreme keys, duplicates and every lock rule.
    idle_phase = PH_STEADY;
    send_word(rwlt_pkg::FN_READ_START, 32'd5, '0);      // empty table: not found
    send_word(rwlt_pkg::FN_EXIT, KEY_ZERO, '1);
    send_word(rwlt_pkg::FN_INVALID, 32'd5, '0);         // missing key beats invalid
    send_word(rwlt_pkg::FN_LOAD, KEY_MIN, '1);
    send_word(rwlt_pkg::FN_LOAD, KEY_MAX, '0);
    send_word(rwlt_pkg::FN_LOAD, KEY_ZERO, 64'h0123_4567_89ab_cdef);
    send_word(rwlt_pkg::FN_LOAD, KEY_NEG1, rand_payload());
    send_word(rwlt_pkg::FN_LOAD, KEY_MIN, 64'h5555_aaaa_5555_aaaa); // duplicate hidden
    send_word(rwlt_pkg::FN_INVALID, KEY_ZERO, '0);      // found: protocol error
    send_word(rwlt_pkg::FN_READ_DONE, KEY_ZERO, '0);    // no readers
    send_word(rwlt_pkg::FN_READ_START, KEY_MIN, '0);
    send_word(rwlt_pkg::FN_WRITE_LOCK, KEY_MIN, '0);    // readers present: busy
    send_word(rwlt_pkg::FN_READ_DONE, KEY_MIN, '0);
    send_word(rwlt_pkg::FN_COMMIT, KEY_MAX, '1);        // no writer
    send_word(rwlt_pkg::FN_UNLOCK, KEY_MAX, '0);        // no writer
    send_word(rwlt_pkg::FN_WRITE_LOCK, KEY_MAX, '0);
    send_word(rwlt_pkg::FN_READ_START, KEY_MAX, '0);    // writer present: busy
    send_word(rwlt_pkg::FN_WRITE_LOCK, KEY_MAX, '0);    // second writer: busy
    send_word(rwlt_pkg::FN_COMMIT, KEY_MAX, rand_payload());
    send_word(rwlt_pkg::FN_UNLOCK, KEY_MAX, '0);
    send_word(rwlt_pkg::FN_READ_START, KEY_MAX, '0);    // sees the committed data
    send_word(rwlt_pkg::FN_READ_DONE, KEY_MAX, '0);
    send_word(rwlt_pkg::FN_EXIT, KEY_NEG1, '0);

    // Hold the receiver off while words keep coming, so the row backs up
    // and the in channel stalls.
    hold_go = 1'b1;
    repeat (60) begin
      k = pick_key();
      send_word($urandom_range(1) ? rwlt_pkg::FN_READ_START : rwlt_pkg::FN_READ_DONE,
                k, rand_payload());
    end

    // Pause the sender until every word is back, then saturate the reader
    // count of one record.
    drain();
    repeat (rwlt_pkg::MAX_READERS + 1) send_word(rwlt_pkg::FN_READ_START, KEY_ZERO, '0);
    send_word(rwlt_pkg::FN_WRITE_LOCK, KEY_ZERO, '0);   // readers present: busy
    send_word(rwlt_pkg::FN_READ_DONE, KEY_ZERO, '0);
    send_word(rwlt_pkg::FN_READ_START, KEY_ZERO, '0);   // room for one again
    send_word(rwlt_pkg::FN_READ_START, KEY_ZERO, '0);   // full count: busy

    // Random traffic: mostly well-formed reader and writer sequences on known
    // keys, some loads until the table fills, the rest noise.
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      idle_phase = idle_phase_t'(((words_sent - base) / 40) % 4);
      pick = $urandom_range(99);
      k    = pick_key();
      if (pick < 30) begin
        send_word(rwlt_pkg::FN_READ_START, k, rand_payload());
        if ($urandom_range(3) == 0)
          send_word(rwlt_pkg::func_t'($urandom_range(7)), pick_key(), rand_payload());
        send_word(rwlt_pkg::FN_READ_DONE, k, rand_payload());
      end else if (pick < 60) begin
        send_word(rwlt_pkg::FN_WRITE_LOCK, k, rand_payload());
        send_word(rwlt_pkg::FN_COMMIT, k, rand_payload());
        if ($urandom_range(1)) send_word(rwlt_pkg::FN_READ_START, k, rand_payload());
        send_word(rwlt_pkg::FN_UNLOCK, k, rand_payload());
      end else if (pick < 70) begin
        send_word(rwlt_pkg::FN_LOAD, $urandom, rand_payload());
      end else begin
        send_word(rwlt_pkg::func_t'($urandom_range(7)), k, rand_payload());
      end
      // Now and then let everything drain in the middle of a phase.
      if ($urandom_range(99) == 0) drain();
    end

    drain();
    repeat (2 * rwlt_pkg::TABLE_DEPTH + 8) @(negedge clk);
    if (mismatches == 0)
      $display("record_reader_writer_lock_table: match");
    else
      $display("record_reader_writer_lock_table: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("record_reader_writer_lock_table: mismatch");
    $finish;
  end

endmodule

/* record_reader_writer_lock_table.f */
hdl/rwlt_pkg.sv
hdl/rwlt_cell.sv
hdl/record_reader_writer_lock_table.sv
sim/lock_table_checker.sv
sim/record_reader_writer_lock_table_tb.sv
